### rtl/universal_hash_interval_lookup_core_assert.svh
// Assertion macros for the hash interval lookup core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef UNIVERSAL_HASH_INTERVAL_LOOKUP_CORE_ASSERT_SVH
`define UNIVERSAL_HASH_INTERVAL_LOOKUP_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, cond, prop)
`define ASSERT_NXT(lbl, cond, prop)
`endif
`endif

### rtl/uhil_pkg.sv
// Shared types and constants of the hash interval lookup core.
// No dependencies.
`timescale 1ns / 1ps

package uhil_pkg;

    localparam int KEY_W   = 32;
    localparam int SLOT_W  = 14;
    localparam int CNT_W   = 15;
    localparam int TOTAL_W = 13;
    localparam int OCC_W   = 32;
    localparam int DVD_W   = 33;
    localparam int STEP_W  = 6;
    localparam logic [STEP_W-1:0] MOD_STEPS = 6'd33;

    typedef enum logic [1:0] {
        OP_FIND = 2'd0,
        OP_CELL = 2'd1,
        OP_ITEM = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_MULT  = 2'd0,
        CFG_ADD   = 2'd1,
        CFG_MOD   = 2'd2,
        CFG_TOTAL = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_GO,
        S_WAIT,
        S_ADD,
        S_TOTAL,
        S_BREAD,
        S_BLOAD,
        S_IREAD,
        S_ICMP,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        RED_P1,
        RED_P2,
        RED_TOTAL
    } red_t;

    typedef struct packed {
        logic [SLOT_W-1:0] start;
        logic [CNT_W-1:0]  count;
    } bucket_cell_t;

    typedef struct packed {
        logic [KEY_W-1:0] left;
        logic [KEY_W-1:0] right;
        logic [OCC_W-1:0] occ;
    } item_rec_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [KEY_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [KEY_W-1:0] rem;
    } mod_rsp_t;

endpackage

### rtl/uhil_ifs.sv
// Valid/ready channel interfaces: command words in, result words out.
// Depends on uhil_pkg.
`timescale 1ns / 1ps

interface uhil_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [uhil_pkg::KEY_W-1:0]    key_left;
    logic [uhil_pkg::KEY_W-1:0]    key_right;
    logic [uhil_pkg::SLOT_W-1:0]   slot;
    logic [uhil_pkg::SLOT_W-1:0]   cell_start;
    logic [uhil_pkg::CNT_W-1:0]    cell_count;
    logic [uhil_pkg::OCC_W-1:0]    occ_value;

    modport source (
        output valid, opcode, key_left, key_right, slot, cell_start, cell_count, occ_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, key_left, key_right, slot, cell_start, cell_count, occ_value,
        output ready
    );
endinterface

interface uhil_res_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [uhil_pkg::OCC_W-1:0]    occ_index;
    logic [uhil_pkg::SLOT_W-1:0]   item_slot;

    modport source (
        output valid, found, occ_index, item_slot,
        input  ready
    );
    modport sink (
        input  valid, found, occ_index, item_slot,
        output ready
    );
endinterface

### rtl/universal_hash_interval_lookup_core.sv
// Channel   Dir  Words carried
// cmd       in   find / bucket cell write / item record write
// res       out  found, occ_index, item_slot (one word per find)
// cfg_*     in   hash_mult, hash_add, hash_modulus, bucket_total
//
// In-range writes go into the tables when accepted. A find computes three
// remainders in turn on one bit-serial unit (a zero modulus skips two, a zero
// bucket total one), then compares the bucket's items one by one.
// No reset sweep; memories hold garbage until written.
// cmd.ready is low while a find runs; a finished word waits in the res register.
`timescale 1ns / 1ps
`include "universal_hash_interval_lookup_core_assert.svh"

module universal_hash_interval_lookup_core #(
    parameter int unsigned BUCKET_DEPTH = 4096,
    parameter int unsigned ITEM_DEPTH   = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    uhil_cmd_if.sink    cmd,
    uhil_res_if.source  res,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import uhil_pkg::*;

    localparam int BA_W = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int IA_W = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1;

    state_t state_reg, state_next;
    red_t   red_reg, red_next;

    logic [KEY_W-1:0]   mult_reg, add_reg, mod_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic [KEY_W-1:0]   key_left_reg, key_right_reg;
    logic [DVD_W-1:0]   val_reg, val_next;
    logic [15:0]        addr_reg, addr_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic               found_reg, found_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;

    logic               res_valid_reg;
    logic               res_found_reg;
    logic [OCC_W-1:0]   res_occ_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic               res_load;

    logic               cmd_fire;
    logic               find_fire;
    logic [KEY_W-1:0]   prod_lo;
    logic [DVD_W-1:0]   sum;
    logic [31:0]        slot_ext;
    logic [31:0]        addr_ext;

    mod_req_t           mod_req;
    mod_rsp_t           mod_rsp;

    logic               bucket_we, item_we;
    bucket_cell_t       bucket_wdata, bucket_rdata;
    item_rec_t          item_wdata, item_rdata;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign find_fire = cmd_fire && (cmd.opcode == OP_FIND);

    assign slot_ext  = 32'(cmd.slot);
    assign addr_ext  = 32'(addr_reg);
    assign bucket_we = cmd_fire && (cmd.opcode == OP_CELL) && (slot_ext < BUCKET_DEPTH);
    assign item_we   = cmd_fire && (cmd.opcode == OP_ITEM) && (slot_ext < ITEM_DEPTH);

    assign bucket_wdata.start = cmd.cell_start;
    assign bucket_wdata.count = cmd.cell_count;
    assign item_wdata.left    = cmd.key_left;
    assign item_wdata.right   = cmd.key_right;
    assign item_wdata.occ     = cmd.occ_value;

    // low half of the product only, wraps at 32 bits
    assign prod_lo   = key_left_reg * mult_reg;
    assign sum       = val_reg + {1'b0, add_reg};

    uhil_mod_unit u_mod (
        .clk (clk),
        .rst_n (rst_n),
        .req (mod_req),
        .rsp (mod_rsp)
    );

    uhil_tables #(
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .ITEM_DEPTH   (ITEM_DEPTH)
    ) u_tables (
        .clk          (clk),
        .bucket_we    (bucket_we),
        .bucket_waddr (slot_ext[BA_W-1:0]),
        .bucket_wdata (bucket_wdata),
        .bucket_raddr (val_reg[BA_W-1:0]),
        .bucket_rdata (bucket_rdata),
        .item_we      (item_we),
        .item_waddr   (slot_ext[IA_W-1:0]),
        .item_wdata   (item_wdata),
        .item_raddr   (addr_ext[IA_W-1:0]),
        .item_rdata   (item_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        red_next   = red_reg;
        val_next   = val_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        found_next = found_reg;
        occ_next   = occ_reg;
        slot_next  = slot_reg;
        mod_req    = '0;
        res_load   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (find_fire)
                begin
                    found_next = 1'b0;
                    occ_next   = '0;
                    slot_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                val_next = {1'b0, prod_lo};
                if (mod_reg != '0)
                begin
                    red_next   = RED_P1;
                    state_next = S_GO;
                end
                else
                    state_next = S_ADD;
            end
            S_GO:
            begin
                mod_req.start    = 1'b1;
                mod_req.dividend = val_reg;
                mod_req.divisor  = (red_reg == RED_TOTAL) ? 32'(total_reg) : mod_reg;
                state_next       = S_WAIT;
            end
            S_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    val_next = {1'b0, mod_rsp.rem};
                    unique case (red_reg)
                        RED_P1:    state_next = S_ADD;
                        RED_P2:    state_next = S_TOTAL;
                        RED_TOTAL: state_next = S_BREAD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                if (mod_reg != '0)
                begin
                    val_next   = sum;
                    red_next   = RED_P2;
                    state_next = S_GO;
                end
                else
                begin
                    // no modulus: the sum wraps at 32 bits
                    val_next   = {1'b0, sum[KEY_W-1:0]};
                    state_next = S_TOTAL;
                end
            end
            S_TOTAL:
            begin
                if (total_reg == '0)
                    state_next = S_FIN;
                else
                begin
                    red_next   = RED_TOTAL;
                    state_next = S_GO;
                end
            end
            S_BREAD:
            begin
                if (val_reg < DVD_W'(BUCKET_DEPTH))
                    state_next = S_BLOAD;
                else
                    state_next = S_FIN;
            end
            S_BLOAD:
            begin
                addr_next  = {2'b00, bucket_rdata.start};
                left_next  = bucket_rdata.count;
                state_next = S_IREAD;
            end
            S_IREAD:
            begin
                if (left_reg == '0 || addr_ext >= ITEM_DEPTH)
                    state_next = S_FIN;
                else
                    state_next = S_ICMP;
            end
            S_ICMP:
            begin
                if (item_rdata.left == key_left_reg && item_rdata.right == key_right_reg)
                begin
                    found_next = 1'b1;
                    occ_next   = item_rdata.occ;
                    slot_next  = addr_reg[SLOT_W-1:0];
                    state_next = S_FIN;
                end
                else
                begin
                    addr_next  = addr_reg + 16'd1;
                    left_next  = left_reg - 1'b1;
                    state_next = S_IREAD;
                end
            end
            S_FIN:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            red_reg       <= RED_P1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            red_reg   <= red_next;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg  <= 32'd1;
            add_reg   <= 32'd0;
            mod_reg   <= 32'd2;
            total_reg <= 13'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MULT:  mult_reg  <= cfg_data;
                CFG_ADD:   add_reg   <= cfg_data;
                CFG_MOD:   mod_reg   <= cfg_data;
                CFG_TOTAL: total_reg <= cfg_data[TOTAL_W-1:0];
                default:   mult_reg  <= mult_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (find_fire)
        begin
            key_left_reg  <= cmd.key_left;
            key_right_reg <= cmd.key_right;
        end
        val_reg   <= val_next;
        addr_reg  <= addr_next;
        left_reg  <= left_next;
        found_reg <= found_next;
        occ_reg   <= occ_next;
        slot_reg  <= slot_next;
        if (res_load)
        begin
            res_found_reg <= found_reg;
            res_occ_reg   <= occ_reg;
            res_slot_reg  <= slot_reg;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.found     = res_found_reg;
    assign res.occ_index = res_occ_reg;
    assign res.item_slot = res_slot_reg;

    `ASSERT_NXT(a_fin_loads_word, (state_reg == S_FIN) && !res_valid_reg, res_valid_reg)
    `ASSERT_IMP(a_done_only_in_wait, mod_rsp.done, state_reg == S_WAIT)
    `ASSERT_IMP(a_start_unit_idle, mod_req.start, !mod_rsp.busy)

endmodule

### rtl/uhil_mod_unit.sv
// Shared restoring remainder unit, one dividend bit per cycle.
// Depends on uhil_pkg.
`timescale 1ns / 1ps

module uhil_mod_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  uhil_pkg::mod_req_t req,
    output uhil_pkg::mod_rsp_t rsp
);
    import uhil_pkg::*;

    logic              busy_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [KEY_W-1:0]  rem_reg;
    logic [KEY_W-1:0]  dsr_reg;
    logic [DVD_W-1:0]  shifted;
    logic [DVD_W-1:0]  diff;
    logic              ge;

    always_comb
    begin
        shifted = {rem_reg, dvd_reg[DVD_W-1]};
        ge      = shifted >= {1'b0, dsr_reg};
        diff    = shifted - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= MOD_STEPS;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
            else
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            // remainder stays below the divisor, so 32 bits always hold it
            rem_reg <= ge ? diff[KEY_W-1:0] : shifted[KEY_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = busy_reg && (cnt_reg == '0);
    assign rsp.rem  = rem_reg;

endmodule

### rtl/uhil_tables.sv
// Bucket cell memory and item record memory, registered reads.
// Depends on uhil_pkg.
`timescale 1ns / 1ps

module uhil_tables #(
    parameter int unsigned BUCKET_DEPTH = 4096,
    parameter int unsigned ITEM_DEPTH   = 16384,
    localparam int BA_W = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1,
    localparam int IA_W = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   bucket_we,
    input  logic [BA_W-1:0]        bucket_waddr,
    input  uhil_pkg::bucket_cell_t bucket_wdata,
    input  logic [BA_W-1:0]        bucket_raddr,
    output uhil_pkg::bucket_cell_t bucket_rdata,
    input  logic                   item_we,
    input  logic [IA_W-1:0]        item_waddr,
    input  uhil_pkg::item_rec_t    item_wdata,
    input  logic [IA_W-1:0]        item_raddr,
    output uhil_pkg::item_rec_t    item_rdata
);
    import uhil_pkg::*;

    bucket_cell_t bucket_mem [BUCKET_DEPTH];
    item_rec_t    item_mem   [ITEM_DEPTH];
    bucket_cell_t bucket_rd_reg;
    item_rec_t    item_rd_reg;

    always_ff @(posedge clk)
    begin
        if (bucket_we)
            bucket_mem[bucket_waddr] <= bucket_wdata;
        bucket_rd_reg <= bucket_mem[bucket_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (item_we)
            item_mem[item_waddr] <= item_wdata;
        item_rd_reg <= item_mem[item_raddr];
    end

    assign bucket_rdata = bucket_rd_reg;
    assign item_rdata   = item_rd_reg;

endmodule
